FILE: sv/cgrb_pkg.sv
// ----------------------------------------------------------------------------
// cgrb_pkg: shared types and constants for the glyph row blitter
// Holds field widths, configuration register indexes and the record that
// the clipping stage hands to the pixel emitter.
// ----------------------------------------------------------------------------
package cgrb_pkg;

    // Number of pixel columns in one glyph row word, one lane per column.
    localparam int RowWordBits    = 32;
    localparam int ColW           = $clog2(RowWordBits);
    localparam int MaxGlyphHeight = 64;
    localparam int ScreenLimit    = 4096;

    // Field widths.
    localparam int OriginW = 16;
    localparam int GwW     = 6;
    localparam int GhW     = 7;
    localparam int RowW    = 6;
    localparam int ScrW    = 13;
    localparam int CoordW  = 12;
    localparam int CfgAddrW = 2;

    // Configuration register indexes.
    typedef enum logic [CfgAddrW-1:0] {
        CFG_SCREEN_WIDTH  = 2'd0,
        CFG_SCREEN_HEIGHT = 2'd1
    } cfg_addr_t;

    // Result of clipping one row against the screen.
    typedef struct packed {
        logic              visible;
        logic [CoordW-1:0] first_x;
        logic [CoordW-1:0] py;
        logic [ColW-1:0]   off;
        logic [ColW:0]     end_col;
    } clip_t;

endpackage

FILE: sv/cgrb_clip.sv
// ----------------------------------------------------------------------------
// cgrb_clip: clip one glyph row against the framebuffer
// Works out the screen row, the first visible screen column and the range
// of glyph columns that land on screen, using signed comparisons.
// ----------------------------------------------------------------------------
module cgrb_clip
    import cgrb_pkg::*;
(
    input  logic signed [OriginW-1:0] origin_x,
    input  logic signed [OriginW-1:0] origin_y,
    input  logic [GwW-1:0]            glyph_width,
    input  logic [GhW-1:0]            glyph_height,
    input  logic [RowW-1:0]           row_number,
    input  logic [ScrW-1:0]           screen_width,
    input  logic [ScrW-1:0]           screen_height,
    output clip_t                     clip
);

    logic [GwW-1:0]      gw_eff;
    logic [GhW-1:0]      gh_eff;
    logic [ScrW-1:0]     sw_eff;
    logic [ScrW-1:0]     sh_eff;
    logic signed [17:0]  ox_ext;
    logic signed [17:0]  py_ext;
    logic signed [17:0]  ox_end;
    logic signed [17:0]  ox_neg;
    logic                empty_size;
    logic                row_out;
    logic                col_out;
    logic [CoordW-1:0]   first_x;
    logic [ColW-1:0]     off;
    logic [GwW-1:0]      count_raw;
    logic [ScrW-1:0]     room;
    logic [GwW-1:0]      count;

    // Cap sizes to what the hardware supports.
    always_comb
    begin
        gw_eff = (glyph_width > GwW'(RowWordBits)) ? GwW'(RowWordBits) : glyph_width;
        gh_eff = (glyph_height > GhW'(MaxGlyphHeight)) ? GhW'(MaxGlyphHeight) : glyph_height;
        sw_eff = (screen_width > ScrW'(ScreenLimit)) ? ScrW'(ScreenLimit) : screen_width;
        sh_eff = (screen_height > ScrW'(ScreenLimit)) ? ScrW'(ScreenLimit) : screen_height;
    end

    // Vertical and horizontal rejection tests.
    always_comb
    begin
        ox_ext = 18'(origin_x);
        py_ext = 18'(origin_y) + $signed({12'd0, row_number});
        ox_end = ox_ext + $signed({12'd0, gw_eff});
        ox_neg = -ox_ext;
        empty_size = (gw_eff == '0) || (gh_eff == '0) || (sw_eff == '0) || (sh_eff == '0)
                     || ({1'b0, row_number} >= gh_eff);
        row_out = py_ext[17] || (py_ext >= $signed({5'd0, sh_eff}));
        col_out = (ox_ext >= $signed({5'd0, sw_eff})) || ox_end[17] || (ox_end == '0);
    end

    // Visible column range; only meaningful when the row is not rejected.
    always_comb
    begin
        first_x   = origin_x[OriginW-1] ? '0 : ox_ext[CoordW-1:0];
        off       = origin_x[OriginW-1] ? ox_neg[ColW-1:0] : '0;
        count_raw = gw_eff - {1'b0, off};
        room      = sw_eff - {1'b0, first_x};
        count     = ({7'd0, count_raw} > room) ? room[GwW-1:0] : count_raw;

        clip.visible = !(empty_size || row_out || col_out);
        clip.first_x = first_x;
        clip.py      = py_ext[CoordW-1:0];
        clip.off     = off;
        clip.end_col = (ColW+1)'({1'b0, off} + count);
    end

endmodule

FILE: sv/cgrb_lane.sv
// ----------------------------------------------------------------------------
// cgrb_lane: per-column lane
// Decides for one glyph column whether it falls in the visible range and
// picks its foreground bit from the row word.
// ----------------------------------------------------------------------------
module cgrb_lane
    import cgrb_pkg::*;
(
    input  logic [ColW-1:0]        lane_idx,
    input  logic [ColW-1:0]        off,
    input  logic [ColW:0]          end_col,
    input  logic [RowWordBits-1:0] row_bits,
    output logic                   vis,
    output logic                   fg
);

    logic [ColW-1:0] bit_sel;

    // Column zero is the most significant bit of the row word.
    always_comb
    begin
        bit_sel = ColW'(RowWordBits - 1) - lane_idx;
        vis     = (lane_idx >= off) && ({1'b0, lane_idx} < end_col);
        fg      = row_bits[bit_sel];
    end

endmodule

FILE: sv/cgrb_emit.sv
// ----------------------------------------------------------------------------
// cgrb_emit: merge lane results and emit pixels
// Latches the visibility and foreground masks from the lanes and walks the
// visible columns left to right, one pixel word per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module cgrb_emit
    import cgrb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   pend,
    input  clip_t                  clip,
    input  logic [RowWordBits-1:0] vis_mask,
    input  logic [RowWordBits-1:0] fg_mask,
    output logic                   take,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [CoordW-1:0]      pixel_x,
    output logic [CoordW-1:0]      pixel_y,
    output logic                   use_foreground,
    output logic                   last_pixel
);

    logic                   active_reg, active_next;
    logic [ColW-1:0]        col_reg, col_next;
    logic [CoordW-1:0]      x_reg, x_next;
    logic [CoordW-1:0]      y_reg, y_next;
    logic [RowWordBits-1:0] vis_reg, vis_next;
    logic [RowWordBits-1:0] fg_reg, fg_next;
    logic [ColW-1:0]        col_inc;
    logic                   last;
    logic                   done;

    // Last pixel when the next column is off the visible range or past the end of the row word.
    always_comb
    begin
        col_inc = col_reg + 1'b1;
        last    = (col_reg == ColW'(RowWordBits - 1)) || !vis_reg[col_inc];
        done    = active_reg && out_ready && last;
        take    = pend && (!active_reg || done);
    end

    // Next state of the walk.
    always_comb
    begin
        active_next = active_reg;
        col_next    = col_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        vis_next    = vis_reg;
        fg_next     = fg_reg;
        if (take)
        begin
            active_next = clip.visible;
            col_next    = clip.off;
            x_next      = clip.first_x;
            y_next      = clip.py;
            vis_next    = vis_mask;
            fg_next     = fg_mask;
        end
        else if (done)
        begin
            active_next = 1'b0;
        end
        else if (active_reg && out_ready)
        begin
            col_next = col_inc;
            x_next   = x_reg + 1'b1;
        end
    end

    // Control register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        col_reg <= col_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        vis_reg <= vis_next;
        fg_reg  <= fg_next;
    end

    // Output word.
    assign out_valid      = active_reg;
    assign pixel_x        = x_reg;
    assign pixel_y        = y_reg;
    assign use_foreground = fg_reg[col_reg];
    assign last_pixel     = last;

    // The column being shown is always inside the visible range.
    a_col_visible: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> vis_reg[col_reg])
        else $error("emitter column outside visible range");

    // A stalled word keeps its column and stays valid.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg && !out_ready) |=> (active_reg && $stable(col_reg) && $stable(x_reg)))
        else $error("stalled pixel word changed");

    // Moving to the next pixel advances the screen column by one.
    a_x_step: assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg && out_ready && !last) |=> (x_reg == $past(x_reg) + 1'b1))
        else $error("screen column did not advance by one");

endmodule

FILE: sv/clipped_glyph_row_blitter_core.sv
// ----------------------------------------------------------------------------
// clipped_glyph_row_blitter_core: clipped one-bit glyph row blitter
// Clips a glyph row against the framebuffer and streams visible pixels.
// ----------------------------------------------------------------------------
// Each input word carries one row of a 1bpp glyph plus its signed origin,
// size and row number. The row is clipped against screen_width and
// screen_height (registers 0 and 1, reset 512 and 448, values above 4096
// act as 4096) and one output word per visible pixel follows, left to
// right, with tlast on the final pixel and tuser set for foreground. The
// pixel walker emits one pixel per cycle while m_axis_tready is high; the
// first pixel of a row is offered once the row has passed from the input
// register into the walker's registers. A fully clipped row emits nothing
// but still passes through the input register, and a new row is accepted
// only while that register is empty. The next row is taken into the input
// register and clipped while the current one is still emitting.
// ----------------------------------------------------------------------------
module clipped_glyph_row_blitter_core
    import cgrb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // Input stream.
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // tdata, low bit up: origin_x[15:0], origin_y[31:16], glyph_width[37:32],
    // glyph_height[44:38], row_number[50:45], row_bits[82:51], zero[87:83]
    input  logic [87:0]         s_axis_tdata,
    // Output stream.
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // tdata, low bit up: pixel_x[11:0], pixel_y[23:12]
    output logic [23:0]         m_axis_tdata,
    // tuser: use_foreground[0]
    output logic                m_axis_tuser,
    output logic                m_axis_tlast,
    // Configuration write channel.
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CfgAddrW-1:0] cfg_addr,
    input  logic [ScrW-1:0]     cfg_data
);

    logic                   pend_reg, pend_next;
    logic [82:0]            in_reg;
    logic [ScrW-1:0]        sw_reg;
    logic [ScrW-1:0]        sh_reg;
    logic                   take;
    clip_t                  clip;
    logic [RowWordBits-1:0] row_bits;
    logic [RowWordBits-1:0] vis_mask;
    logic [RowWordBits-1:0] fg_mask;
    logic [CoordW-1:0]      pixel_x;
    logic [CoordW-1:0]      pixel_y;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg <= ScrW'(512);
            sh_reg <= ScrW'(448);
        end
        else if (cfg_valid)
        begin
            case (cfg_addr)
                CFG_SCREEN_WIDTH:  sw_reg <= cfg_data;
                CFG_SCREEN_HEIGHT: sh_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Input register: holds one row until the emitter takes it.
    assign s_axis_tready = !pend_reg;

    always_comb
    begin
        pend_next = pend_reg;
        if (s_axis_tvalid && s_axis_tready)
        begin
            pend_next = 1'b1;
        end
        else if (take)
        begin
            pend_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_reg <= s_axis_tdata[82:0];
        end
    end

    // Clipping of the held row.
    cgrb_clip u_clip (
        .origin_x      ($signed(in_reg[15:0])),
        .origin_y      ($signed(in_reg[31:16])),
        .glyph_width   (in_reg[37:32]),
        .glyph_height  (in_reg[44:38]),
        .row_number    (in_reg[50:45]),
        .screen_width  (sw_reg),
        .screen_height (sh_reg),
        .clip          (clip)
    );

    assign row_bits = in_reg[82:51];

    // One lane per glyph column.
    for (genvar g = 0; g < RowWordBits; g++)
    begin : g_lane
        cgrb_lane u_lane (
            .lane_idx (ColW'(g)),
            .off      (clip.off),
            .end_col  (clip.end_col),
            .row_bits (row_bits),
            .vis      (vis_mask[g]),
            .fg       (fg_mask[g])
        );
    end

    // Merge lane masks and walk the visible pixels.
    cgrb_emit u_emit (
        .clk            (clk),
        .rst_n          (rst_n),
        .pend           (pend_reg),
        .clip           (clip),
        .vis_mask       (vis_mask),
        .fg_mask        (fg_mask),
        .take           (take),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .pixel_x        (pixel_x),
        .pixel_y        (pixel_y),
        .use_foreground (m_axis_tuser),
        .last_pixel     (m_axis_tlast)
    );

    assign m_axis_tdata = {pixel_y, pixel_x};

endmodule
